// ===== hw/rtl/h264rtp_pkg.sv =====
// Shared types and codes for the H.264 RTP to Annex-B depacketizer.
package h264rtp_pkg;

  // One payload byte from the RTP receive path
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_packet;
    logic       last_of_packet;
  } in_item_t;

  // One byte of the Annex-B output stream
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
  } out_item_t;

  // Emit commands passed from the classifier to the emitter
  localparam logic [1:0] KIND_PASS   = 2'd0;  // the byte alone
  localparam logic [1:0] KIND_START3 = 2'd1;  // 00 00 01 then the byte
  localparam logic [1:0] KIND_START4 = 2'd2;  // 00 00 00 01 then the byte

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // Header field masks and NAL unit types
  localparam logic [7:0] HDR_TYPE_FIELD = 8'h1f;
  localparam logic [7:0] HDR_FNRI_FIELD = 8'he0;
  localparam logic [7:0] FU_START_MASK  = 8'h80;
  localparam logic [4:0] TYPE_FU_A      = 5'd28;
  localparam logic [4:0] TYPE_SEI       = 5'd6;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== hw/rtl/h264_rtp_nal_depacketizer.sv =====
// H.264 RTP payload depacketizer: top level, classifier, queue and emitter.
//
// Input channel pkt_*: one RTP payload byte per item (RTP header already
// stripped), marked first_of_packet and last_of_packet. Output channel nal_*:
// the Annex-B byte stream, one byte per item. run_last flags the final byte
// caused by an input item; packet_end also flags it when that input closed
// a packet. An FU-A indicator byte and an FU header without start bit cause
// no output.
// With an empty queue and an idle receiver, the first byte caused by an input
// item is registered in the command queue and then in the output register.
// Throughput: one output byte per cycle while the receiver is ready, set by
// the single output register. Pass-through bytes therefore flow at one item
// per cycle; a packet start becomes five bytes (four for SEI and FU-A starts)
// in the emitter, and the two-entry queue accepts one more command meanwhile.
// Reset (rst, synchronous): clears packet position, fragment flag, queue and
// output valid; the next byte is taken as a packet's first byte.
// When the receiver stalls, the output byte holds, the queue fills and then
// pkt_ready drops until the emitter drains a command.
module h264_rtp_nal_depacketizer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pkt_valid,
  output logic                   pkt_ready,
  input  h264rtp_pkg::in_item_t  pkt_data,
  output logic                   nal_valid,
  input  logic                   nal_ready,
  output h264rtp_pkg::out_item_t nal_data
);

  logic              push_valid;
  logic              push_ready;
  h264rtp_pkg::cmd_t push_cmd;
  logic              pop_valid;
  logic              pop_ready;
  h264rtp_pkg::cmd_t pop_cmd;

  h264rtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pkt_valid  (pkt_valid),
    .pkt_ready  (pkt_ready),
    .pkt_data   (pkt_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  h264rtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  h264rtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .nal_valid (nal_valid),
    .nal_ready (nal_ready),
    .nal_data  (nal_data)
  );

endmodule

// ===== hw/rtl/h264rtp_front.sv =====
// Classifier: accepts payload bytes, tracks packet position, issues emit commands.
module h264rtp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pkt_valid,
  output logic                  pkt_ready,
  input  h264rtp_pkg::in_item_t pkt_data,
  output logic                  push_valid,
  input  logic                  push_ready,
  output h264rtp_pkg::cmd_t     push_cmd
);

  localparam logic [1:0] POS_HEADER = 2'd0;
  localparam logic [1:0] POS_FU_HDR = 2'd1;
  localparam logic [1:0] POS_PASS   = 2'd2;

  logic [1:0] byte_position;
  logic [1:0] byte_position_next;
  logic [7:0] held_header;
  logic [7:0] held_header_next;
  logic       is_fragment;
  logic       is_fragment_next;
  logic       accept;
  logic       emit;
  logic [4:0] nal_type;

  assign pkt_ready = push_ready;
  assign accept    = pkt_valid && pkt_ready;
  assign nal_type  = pkt_data.payload_byte[4:0];

  // Classify the byte and pick the command
  always_comb begin
    byte_position_next = byte_position;
    held_header_next   = held_header;
    is_fragment_next   = is_fragment;
    emit               = 1'b0;
    push_cmd.kind      = h264rtp_pkg::KIND_PASS;
    push_cmd.data      = pkt_data.payload_byte;
    push_cmd.last      = pkt_data.last_of_packet;
    if (pkt_data.first_of_packet || byte_position == POS_HEADER) begin
      if (nal_type == h264rtp_pkg::TYPE_FU_A) begin
        held_header_next   = pkt_data.payload_byte;
        is_fragment_next   = 1'b1;
        byte_position_next = POS_FU_HDR;
      end else begin
        is_fragment_next   = 1'b0;
        byte_position_next = POS_PASS;
        emit               = 1'b1;
        push_cmd.kind      = (nal_type == h264rtp_pkg::TYPE_SEI) ?
                             h264rtp_pkg::KIND_START3 : h264rtp_pkg::KIND_START4;
      end
    end else if (byte_position == POS_FU_HDR && is_fragment) begin
      byte_position_next = POS_PASS;
      // Rebuild the NAL header only on a start fragment
      if ((pkt_data.payload_byte & h264rtp_pkg::FU_START_MASK) != 8'h00) begin
        emit          = 1'b1;
        push_cmd.kind = h264rtp_pkg::KIND_START3;
        push_cmd.data = (held_header & h264rtp_pkg::HDR_FNRI_FIELD) |
                        (pkt_data.payload_byte & h264rtp_pkg::HDR_TYPE_FIELD);
      end
    end else begin
      byte_position_next = POS_PASS;
      emit               = 1'b1;
    end
    if (pkt_data.last_of_packet) begin
      byte_position_next = POS_HEADER;
      is_fragment_next   = 1'b0;
    end
  end

  assign push_valid = pkt_valid && emit;

  // Advance packet state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HEADER;
      held_header   <= 8'h00;
      is_fragment   <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      held_header   <= held_header_next;
      is_fragment   <= is_fragment_next;
    end
  end

endmodule

// ===== hw/rtl/h264rtp_queue.sv =====
// Two-entry command queue between classifier and emitter.
module h264rtp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  h264rtp_pkg::cmd_t push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output h264rtp_pkg::cmd_t pop_cmd
);

  localparam int PtrW = $clog2(h264rtp_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(h264rtp_pkg::QUEUE_DEPTH + 1);

  h264rtp_pkg::cmd_t entries [h264rtp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != CntW'(h264rtp_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(h264rtp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(h264rtp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/h264rtp_back.sv =====
// Emitter: expands each command into start code bytes and the payload byte.
module h264rtp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  h264rtp_pkg::cmd_t      pop_cmd,
  output logic                   nal_valid,
  input  logic                   nal_ready,
  output h264rtp_pkg::out_item_t nal_data
);

  logic [2:0]             step;
  logic [2:0]             run_len;
  logic                   can_load;
  logic                   load;
  logic                   at_end;
  h264rtp_pkg::out_item_t item_next;

  // Result count for the head command
  always_comb begin
    case (pop_cmd.kind)
      h264rtp_pkg::KIND_PASS:   run_len = 3'd1;
      h264rtp_pkg::KIND_START3: run_len = 3'd4;
      h264rtp_pkg::KIND_START4: run_len = 3'd5;
      default:                  run_len = 3'd1;
    endcase
  end

  assign can_load  = !nal_valid || nal_ready;
  assign load      = pop_valid && can_load;
  assign at_end    = step == run_len - 3'd1;
  assign pop_ready = load && at_end;

  // Pick the byte for this step: zeros, then 01, then the data byte
  always_comb begin
    item_next.run_last   = at_end;
    item_next.packet_end = at_end && pop_cmd.last;
    if (at_end) begin
      item_next.out_byte = pop_cmd.data;
    end else if (step == run_len - 3'd2) begin
      item_next.out_byte = 8'h01;
    end else begin
      item_next.out_byte = 8'h00;
    end
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
    end else if (load) begin
      step <= at_end ? 3'd0 : step + 3'd1;
    end
  end

  // Hold the output register until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      nal_valid <= 1'b0;
    end else if (can_load) begin
      nal_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nal_data <= item_next;
    end
  end

endmodule

// ===== hw/rtl/h264rtp_checker.sv =====
// Port-level checks for the depacketizer, bound to the top level.
module h264rtp_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   pkt_valid,
  input logic                   pkt_ready,
  input h264rtp_pkg::in_item_t  pkt_data,
  input logic                   nal_valid,
  input logic                   nal_ready,
  input h264rtp_pkg::out_item_t nal_data
);

  // Output item holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    nal_valid && !nal_ready |=> nal_valid && $stable(nal_data))
    else $error("output item dropped or changed while stalled");

  // No output right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !nal_valid)
    else $error("output valid after reset");

  // Packet end only on the last byte of a run
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    nal_valid && nal_data.packet_end |-> nal_data.run_last)
    else $error("packet_end without run_last");

  // Start code bytes are 00 or 01
  a_start_code: assert property (@(posedge clk) disable iff (rst)
    nal_valid && !nal_data.run_last |-> nal_data.out_byte == 8'h00 ||
                                        nal_data.out_byte == 8'h01)
    else $error("start code byte out of range");

  // A run continues without a gap
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    nal_valid && nal_ready && !nal_data.run_last |=> nal_valid)
    else $error("gap inside a start code run");

endmodule

bind h264_rtp_nal_depacketizer h264rtp_checker u_checker (.*);

// ===== sim/h264_rtp_nal_depacketizer_test.sv =====
// Self-checking testbench for the H.264 RTP to Annex-B depacketizer.
module h264_rtp_nal_depacketizer_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 170;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {
    AT_HEADER,
    AT_FU_HEADER,
    AT_PASS
  } byte_pos_e;

  logic                   clk;
  logic                   rst;
  logic                   pkt_valid;
  logic                   pkt_ready;
  h264rtp_pkg::in_item_t  pkt_data;
  logic                   nal_valid;
  logic                   nal_ready;
  h264rtp_pkg::out_item_t nal_data;

  // Predictor state
  byte_pos_e  pred_pos;
  logic [7:0] pred_held;
  logic       pred_frag;

  h264rtp_pkg::out_item_t expected_annexb[$];
  int                     mismatch_count;
  int                     cycle_count;

  // Idle controls for sender and receiver
  bit tx_idle_on;
  bit rx_idle_on;
  int hold_left;
  int stall_left;

  h264_rtp_nal_depacketizer dut (
    .clk      (clk),
    .rst      (rst),
    .pkt_valid(pkt_valid),
    .pkt_ready(pkt_ready),
    .pkt_data (pkt_data),
    .nal_valid(nal_valid),
    .nal_ready(nal_ready),
    .nal_data (nal_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Work out the Annex-B bytes caused by one accepted payload byte
  task automatic predict_annexb(input h264rtp_pkg::in_item_t it);
    logic [7:0]             burst[$];
    logic [7:0]             masked;
    logic [7:0]             rebuilt;
    logic [4:0]             nal_type;
    h264rtp_pkg::out_item_t res;
    begin
      masked = it.payload_byte & h264rtp_pkg::HDR_TYPE_FIELD;
      nal_type = masked[4:0];
      if (it.first_of_packet || pred_pos == AT_HEADER) begin
        if (nal_type == h264rtp_pkg::TYPE_FU_A) begin
          pred_held = it.payload_byte;
          pred_frag = 1'b1;
          pred_pos = AT_FU_HEADER;
        end else begin
          pred_frag = 1'b0;
          pred_pos = AT_PASS;
          burst = {burst, 8'h00};
          burst = {burst, 8'h00};
          if (nal_type != h264rtp_pkg::TYPE_SEI) burst = {burst, 8'h00};
          burst = {burst, 8'h01};
          burst = {burst, it.payload_byte};
        end
      end else if (pred_pos == AT_FU_HEADER && pred_frag) begin
        pred_pos = AT_PASS;
        if ((it.payload_byte & h264rtp_pkg::FU_START_MASK) != 8'h00) begin
          rebuilt = (pred_held & h264rtp_pkg::HDR_FNRI_FIELD) |
                    (it.payload_byte & h264rtp_pkg::HDR_TYPE_FIELD);
          burst = {burst, 8'h00};
          burst = {burst, 8'h00};
          burst = {burst, 8'h01};
          burst = {burst, rebuilt};
        end
      end else begin
        pred_pos = AT_PASS;
        burst = {burst, it.payload_byte};
      end
      // Flag the final byte of this item's burst
      for (int k = 0; k < burst.size(); k++) begin
        res.out_byte = burst[k];
        res.run_last = (k == burst.size() - 1);
        res.packet_end = res.run_last & it.last_of_packet;
        expected_annexb = {expected_annexb, res};
      end
      if (it.last_of_packet) begin
        pred_pos = AT_HEADER;
        pred_frag = 1'b0;
      end
    end
  endtask

  // Offer one payload byte and hold it until accepted
  task automatic send_payload_byte(input logic [7:0] b, input logic first,
                                   input logic last);
    h264rtp_pkg::in_item_t it;
    int                    gap;
    begin
      it.payload_byte = b;
      it.first_of_packet = first;
      it.last_of_packet = last;
      gap = tx_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
        pkt_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pkt_valid <= 1'b1;
      pkt_data <= it;
      do @(posedge clk); while (!pkt_ready);
      predict_annexb(it);
    end
  endtask

  // Drive the receiver: random stalls plus a long hold when requested
  initial begin
    nal_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        nal_ready <= 1'b0;
      end else if (hold_left > 0) begin
        nal_ready <= 1'b0;
        hold_left--;
      end else begin
        if (stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 50)
          stall_left = pick_gap();
        if (stall_left > 0) begin
          nal_ready <= 1'b0;
          stall_left--;
        end else begin
          nal_ready <= 1'b1;
        end
      end
    end
  end

  // Compare each accepted output item with the oldest expectation
  always @(posedge clk) begin
    h264rtp_pkg::out_item_t want;
    if (!rst && nal_valid && nal_ready) begin
      if (expected_annexb.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: byte %02h run_last %0b packet_end %0b",
                   nal_data.out_byte, nal_data.run_last, nal_data.packet_end);
      end else begin
        want = expected_annexb.pop_front();
        if (nal_data.out_byte !== want.out_byte || nal_data.run_last !== want.run_last ||
            nal_data.packet_end !== want.packet_end) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                     want.out_byte, want.run_last, want.packet_end,
                     nal_data.out_byte, nal_data.run_last, nal_data.packet_end);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Start codes for plain and SEI packets, including header type extremes
  task automatic test_plain_and_sei();
    begin
      send_payload_byte(8'h67, 1'b1, 1'b0);
      send_payload_byte(8'h42, 1'b0, 1'b0);
      send_payload_byte(8'hff, 1'b0, 1'b1);
      send_payload_byte(8'h06, 1'b1, 1'b0);
      send_payload_byte(8'h05, 1'b0, 1'b1);
      send_payload_byte(8'h00, 1'b1, 1'b1);
      send_payload_byte(8'h9f, 1'b1, 1'b1);
    end
  endtask

  // FU-A starts, middle fragments, one-byte and header-only fragments
  task automatic test_fu_a_fragments();
    begin
      send_payload_byte(8'h7c, 1'b1, 1'b0);
      send_payload_byte(8'h85, 1'b0, 1'b0);
      send_payload_byte(8'h00, 1'b0, 1'b1);
      send_payload_byte(8'hfc, 1'b1, 1'b0);
      send_payload_byte(8'h41, 1'b0, 1'b0);
      send_payload_byte(8'haa, 1'b0, 1'b1);
      // start and end bits together, FU header closes the packet
      send_payload_byte(8'h5c, 1'b1, 1'b0);
      send_payload_byte(8'hc6, 1'b0, 1'b1);
      send_payload_byte(8'h1c, 1'b1, 1'b1);
      // no start bit on a last-marked FU header: no output at all
      send_payload_byte(8'h3c, 1'b1, 1'b0);
      send_payload_byte(8'h7f, 1'b0, 1'b1);
    end
  endtask

  // Unmarked packet start and a first mark in the middle of a packet
  task automatic test_marking_cases();
    begin
      send_payload_byte(8'h41, 1'b0, 1'b0);
      send_payload_byte(8'h11, 1'b0, 1'b1);
      send_payload_byte(8'h65, 1'b1, 1'b0);
      send_payload_byte(8'h22, 1'b0, 1'b0);
      send_payload_byte(8'hdc, 1'b1, 1'b0);
      send_payload_byte(8'h87, 1'b0, 1'b1);
    end
  endtask

  // Hold the receiver off long enough that the input side stalls
  task automatic test_backpressure();
    begin
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      hold_left = 150;
      for (int p = 0; p < 3; p++) begin
        send_payload_byte(8'h65, 1'b1, 1'b0);
        for (int k = 0; k < 4; k++)
          send_payload_byte(8'(($urandom)), 1'b0, 1'b0);
        send_payload_byte(8'h3c, 1'b0, 1'b1);
      end
    end
  endtask

  // Mostly well-formed packets with random content, some broken marking
  task automatic test_random_stream();
    int         sent;
    int         pkt_count;
    int         len;
    int         kind;
    int         flaw;
    logic [7:0] b;
    logic       first;
    logic       last;
    begin
      sent = 0;
      pkt_count = 0;
      while (sent < RANDOM_ITEMS) begin
        // Switch idling modes every few packets
        if (pkt_count % 6 == 0) begin
          tx_idle_on = 1'($urandom_range(0, 1));
          rx_idle_on = 1'($urandom_range(0, 1));
        end
        pkt_count++;
        len = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 6) : $urandom_range(7, 16);
        kind = $urandom_range(0, 99);
        flaw = $urandom_range(0, 99);
        for (int k = 0; k < len; k++) begin
          b = 8'($urandom);
          if (k == 0 && kind < 40) b = {b[7:5], h264rtp_pkg::TYPE_FU_A};
          else if (k == 0 && kind < 55) b = {b[7:5], h264rtp_pkg::TYPE_SEI};
          else if (k == 1 && kind < 40) b[7] = ($urandom_range(0, 99) < 65);
          first = (k == 0);
          last = (k == len - 1);
          if (flaw < 8) begin
            first = 1'b0;
          end else if (flaw < 16) begin
            last = 1'b0;
          end else if (flaw < 20) begin
            first = ($urandom_range(0, 7) == 0);
            last = ($urandom_range(0, 7) == 0);
          end
          send_payload_byte(b, first, last);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    pkt_valid <= 1'b0;
    pkt_data <= '0;
    pred_pos = AT_HEADER;
    pred_held = 8'h00;
    pred_frag = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_left = 0;
    stall_left = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_plain_and_sei();
    test_fu_a_fragments();
    test_marking_cases();
    test_backpressure();
    test_random_stream();

    // Drain outstanding bytes, then watch for stray output
    pkt_valid <= 1'b0;
    rx_idle_on = 1'b0;
    while (expected_annexb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_annexb.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
